FILE: sv/owm_pkg.sv
`timescale 1ns / 1ps

package owm_pkg;

  // Command codes carried in the input beat's tuser
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RESET = 2'd1,
    PH_WRITE = 2'd2,
    PH_READ  = 2'd3
  } phase_t;

  // Stages of a reset sequence, kept in bit_index
  localparam logic [2:0] STG_LOW  = 3'd0;
  localparam logic [2:0] STG_WAIT = 3'd1;
  localparam logic [2:0] STG_REST = 3'd2;
  localparam logic [2:0] LAST_BIT = 3'd7;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_REST    = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [2:0] REG_ZERO_LOW      = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [2:0] REG_SLOT_LEN      = 3'd6;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [7:0] presence_wait_us;
    logic [9:0] reset_rest_us;
    logic [5:0] short_low_us;
    logic [6:0] zero_low_us;
    logic [6:0] read_sample_us;
    logic [7:0] slot_len_us;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    reset_low_us:     10'd480,
    presence_wait_us: 8'd70,
    reset_rest_us:    10'd410,
    short_low_us:     6'd6,
    zero_low_us:      7'd60,
    read_sample_us:   7'd15,
    slot_len_us:      8'd70
  };

  typedef struct packed {
    phase_t     phase;
    logic [9:0] time_count;
    logic [2:0] bit_index;
    logic [7:0] shift_byte;
    logic       presence_flag;
    logic [7:0] read_byte;
  } state_t;

  localparam state_t ST_RST = '{
    phase:         PH_IDLE,
    time_count:    10'd0,
    bit_index:     3'd0,
    shift_byte:    8'd0,
    presence_flag: 1'b1,
    read_byte:     8'd0
  };

  typedef struct packed {
    logic       line_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_missing;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

  function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: sv/owm_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one beat.
module owm_step (
  input  owm_pkg::cmd_t   cmd,
  input  logic [7:0]      write_data,
  input  logic            line_in,
  input  owm_pkg::cfg_t   cfg,
  input  owm_pkg::state_t st,
  output owm_pkg::state_t st_nxt,
  output owm_pkg::res_t   res
);

  logic [9:0] t;
  logic [6:0] wr_low;
  logic [6:0] wr_low_nxt;
  logic [7:0] wr_end_raw;
  logic [7:0] wr_end;
  logic [6:0] samp;
  logic [7:0] rd_end;
  logic [7:0] rd_shift;
  logic       done;
  logic       rejected;

  assign t          = st.time_count + 10'd1;
  assign wr_low     = st.shift_byte[0] ? {1'b0, cfg.short_low_us} : cfg.zero_low_us;
  assign wr_end_raw = owm_pkg::max8(cfg.slot_len_us, {1'b0, wr_low});
  assign wr_end     = (wr_end_raw == 8'd0) ? 8'd1 : wr_end_raw;
  assign samp       = (cfg.read_sample_us == 7'd0) ? 7'd1 : cfg.read_sample_us;
  assign rd_end     = owm_pkg::max8(owm_pkg::max8(cfg.slot_len_us, {2'b0, cfg.short_low_us}),
                                    {1'b0, samp});
  assign rd_shift   = (t == {3'b0, samp}) ? {line_in, st.shift_byte[7:1]} : st.shift_byte;

  // next state
  always_comb begin
    st_nxt   = st;
    done     = 1'b0;
    rejected = 1'b0;
    if (cmd != owm_pkg::CMD_TICK) begin
      if (st.phase != owm_pkg::PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        unique case (cmd)
          owm_pkg::CMD_RESET: st_nxt.phase = owm_pkg::PH_RESET;
          owm_pkg::CMD_WRITE: st_nxt.phase = owm_pkg::PH_WRITE;
          default:            st_nxt.phase = owm_pkg::PH_READ;
        endcase
        st_nxt.time_count = 10'd0;
        st_nxt.bit_index  = 3'd0;
        if (cmd == owm_pkg::CMD_WRITE) begin
          st_nxt.shift_byte = write_data;
        end
      end
    end else begin
      unique case (st.phase)
        owm_pkg::PH_IDLE: begin
        end
        owm_pkg::PH_RESET: begin
          st_nxt.time_count = t;
          priority if (st.bit_index == owm_pkg::STG_LOW) begin
            if (t >= cfg.reset_low_us) begin
              st_nxt.bit_index  = owm_pkg::STG_WAIT;
              st_nxt.time_count = 10'd0;
            end
          end else if (st.bit_index == owm_pkg::STG_WAIT) begin
            if (t >= {2'b0, cfg.presence_wait_us}) begin
              st_nxt.presence_flag = line_in;
              st_nxt.bit_index     = owm_pkg::STG_REST;
              st_nxt.time_count    = 10'd0;
            end
          end else begin
            if (t >= cfg.reset_rest_us) begin
              done              = 1'b1;
              st_nxt.phase      = owm_pkg::PH_IDLE;
              st_nxt.bit_index  = 3'd0;
              st_nxt.time_count = 10'd0;
            end
          end
        end
        owm_pkg::PH_WRITE: begin
          if (t >= {2'b0, wr_end}) begin
            st_nxt.shift_byte = {1'b0, st.shift_byte[7:1]};
            st_nxt.time_count = 10'd0;
            if (st.bit_index == owm_pkg::LAST_BIT) begin
              st_nxt.bit_index = 3'd0;
              st_nxt.phase     = owm_pkg::PH_IDLE;
              done             = 1'b1;
            end else begin
              st_nxt.bit_index = st.bit_index + 3'd1;
            end
          end else begin
            st_nxt.time_count = t;
          end
        end
        default: begin
          st_nxt.shift_byte = rd_shift;
          if (t >= {2'b0, rd_end}) begin
            st_nxt.time_count = 10'd0;
            if (st.bit_index == owm_pkg::LAST_BIT) begin
              st_nxt.bit_index = 3'd0;
              st_nxt.phase     = owm_pkg::PH_IDLE;
              st_nxt.read_byte = rd_shift;
              done             = 1'b1;
            end else begin
              st_nxt.bit_index = st.bit_index + 3'd1;
            end
          end else begin
            st_nxt.time_count = t;
          end
        end
      endcase
    end
  end

  // line level after the update
  assign wr_low_nxt = st_nxt.shift_byte[0] ? {1'b0, cfg.short_low_us} : cfg.zero_low_us;

  always_comb begin
    res = '0;
    unique case (st_nxt.phase)
      owm_pkg::PH_RESET: res.line_low = (st_nxt.bit_index == owm_pkg::STG_LOW);
      owm_pkg::PH_WRITE: res.line_low = (st_nxt.time_count < {3'b0, wr_low_nxt});
      owm_pkg::PH_READ:  res.line_low = (st_nxt.time_count < {4'b0, cfg.short_low_us});
      default:           res.line_low = 1'b0;
    endcase
    res.busy_res         = (st_nxt.phase != owm_pkg::PH_IDLE);
    res.done_res         = done;
    res.presence_missing = st_nxt.presence_flag;
    res.read_data        = st_nxt.read_byte;
    res.rejected         = rejected;
  end

endmodule

FILE: sv/one_wire_master_byte_engine.sv
`timescale 1ns / 1ps

// 1-Wire bus master byte engine. Every input beat is either a one-microsecond
// tick or a start command (reset, write byte, read byte); each beat yields
// exactly one result beat carrying the bus drive level, busy/done flags, the
// presence result of the last reset, the last read byte and a reject flag for
// a start that arrived while busy. Throughput is one beat per clock: the whole
// state update is combinational and lands in an output register, and in_tready
// stays high as long as that register is empty or being drained. Each result
// beat follows in the cycle after its input beat. Timing registers sit on an
// APB port at byte address 4*index and should only be written while idle.
module one_wire_master_byte_engine (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] write_data, [8] line_in, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] line_low, [1] busy_res, [2] done_res,
                                  // [3] presence_missing, [11:4] read_data,
                                  // [12] rejected, rest zero

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  owm_pkg::cfg_t   cfg_r;
  owm_pkg::state_t st_r;
  owm_pkg::state_t st_nxt;
  owm_pkg::res_t   res_nxt;
  owm_pkg::res_t   res_r;
  owm_pkg::cmd_t   cmd;
  logic            out_tvalid_r;
  logic            in_fire;
  logic            cfg_wr;
  logic [2:0]      cfg_idx;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= owm_pkg::CFG_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        owm_pkg::REG_RESET_LOW:     cfg_r.reset_low_us     <= cfg_pwdata[9:0];
        owm_pkg::REG_PRESENCE_WAIT: cfg_r.presence_wait_us <= cfg_pwdata[7:0];
        owm_pkg::REG_RESET_REST:    cfg_r.reset_rest_us    <= cfg_pwdata[9:0];
        owm_pkg::REG_SHORT_LOW:     cfg_r.short_low_us     <= cfg_pwdata[5:0];
        owm_pkg::REG_ZERO_LOW:      cfg_r.zero_low_us      <= cfg_pwdata[6:0];
        owm_pkg::REG_READ_SAMPLE:   cfg_r.read_sample_us   <= cfg_pwdata[6:0];
        owm_pkg::REG_SLOT_LEN:      cfg_r.slot_len_us      <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      owm_pkg::REG_RESET_LOW:     cfg_prdata = {22'd0, cfg_r.reset_low_us};
      owm_pkg::REG_PRESENCE_WAIT: cfg_prdata = {24'd0, cfg_r.presence_wait_us};
      owm_pkg::REG_RESET_REST:    cfg_prdata = {22'd0, cfg_r.reset_rest_us};
      owm_pkg::REG_SHORT_LOW:     cfg_prdata = {26'd0, cfg_r.short_low_us};
      owm_pkg::REG_ZERO_LOW:      cfg_prdata = {25'd0, cfg_r.zero_low_us};
      owm_pkg::REG_READ_SAMPLE:   cfg_prdata = {25'd0, cfg_r.read_sample_us};
      owm_pkg::REG_SLOT_LEN:      cfg_prdata = {24'd0, cfg_r.slot_len_us};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  // Accept whenever the result register is free or drains this cycle.
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid & in_tready;
  assign cmd       = owm_pkg::cmd_t'(in_tuser);

  owm_step u_step (
    .cmd        (cmd),
    .write_data (in_tdata[7:0]),
    .line_in    (in_tdata[8]),
    .cfg        (cfg_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .res        (res_nxt)
  );

  // bus state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= owm_pkg::ST_RST;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'd0, res_r.rejected, res_r.read_data, res_r.presence_missing,
                       res_r.done_res, res_r.busy_res, res_r.line_low};

  // ---------------------------------------------------------------- checks
  // a rejected start never disturbs a running operation
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && res_r.rejected |-> res_r.busy_res)
    else $error("rejected beat reported as idle");

  // completion always returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && res_r.done_res |-> !res_r.busy_res && !res_r.rejected)
    else $error("done beat still busy");

  // a start taken while idle shows busy and is not rejected
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (cmd != owm_pkg::CMD_TICK) && (st_r.phase == owm_pkg::PH_IDLE)
    |=> res_r.busy_res && !res_r.rejected && out_tvalid_r)
    else $error("idle start not reported busy");

  // state holds while no beat is accepted
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(st_r))
    else $error("state moved without an input beat");

endmodule

FILE: sim/owm_bus_checker.sv
`timescale 1ns / 1ps

// Watches the input, result and APB channels of the byte engine, runs its own
// model of the bus master on every accepted input beat and checks each result
// beat against the oldest prediction.
module owm_bus_checker
  import owm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,

  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,

  output int          fail_count,
  output int          results_due,
  output logic        engine_busy
);

  typedef struct packed {
    logic       line_low;
    logic       busy;
    logic       done;
    logic       no_presence;
    logic [7:0] read_data;
    logic       rejected;
  } bus_result_t;

  // timing registers
  logic [9:0] reset_low_us;
  logic [7:0] presence_wait_us;
  logic [9:0] reset_rest_us;
  logic [5:0] short_low_us;
  logic [6:0] zero_low_us;
  logic [6:0] read_sample_us;
  logic [7:0] slot_len_us;

  // engine state
  phase_t     phase;
  logic [9:0] tick_count;
  logic [2:0] slot_idx;     // bit slot, or reset stage
  logic [7:0] shifter;
  logic       no_presence;
  logic [7:0] last_read;

  bus_result_t expected_replies[$];
  bus_result_t want;
  logic [31:0] reg_now;

  int   mismatches = 0;
  int   due = 0;
  logic busy_flag = 1'b0;

  assign fail_count  = mismatches;
  assign results_due = due;
  assign engine_busy = busy_flag;

  function automatic int unsigned umax(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

  function automatic int unsigned write_low_len();
    return shifter[0] ? short_low_us : zero_low_us;
  endfunction

  function automatic int unsigned sample_point();
    return (read_sample_us == 0) ? 1 : read_sample_us;
  endfunction

  function automatic logic drive_low();
    case (phase)
      PH_RESET: return slot_idx == STG_LOW;
      PH_WRITE: return tick_count < write_low_len();
      PH_READ:  return tick_count < short_low_us;
      default:  return 1'b0;
    endcase
  endfunction

  // advance within a slot; true once the eighth slot has ended
  function automatic logic end_of_slot(input int unsigned slot_end, input int unsigned t);
    if (t < slot_end) begin
      tick_count = t[9:0];
      return 1'b0;
    end
    tick_count = '0;
    if (slot_idx == LAST_BIT) begin
      slot_idx = '0;
      return 1'b1;
    end
    slot_idx = slot_idx + 3'd1;
    return 1'b0;
  endfunction

  function automatic bus_result_t predict_beat(input cmd_t c, input logic [7:0] wd,
                                               input logic ln);
    bus_result_t r;
    int unsigned t;
    int unsigned slot_end;
    logic        done;
    logic        rej;
    done = 1'b0;
    rej  = 1'b0;
    if (c != CMD_TICK) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tick_count = '0;
        slot_idx   = '0;
        case (c)
          CMD_RESET: phase = PH_RESET;
          CMD_WRITE: begin
            phase   = PH_WRITE;
            shifter = wd;
          end
          default:   phase = PH_READ;
        endcase
      end
    end else if (phase != PH_IDLE) begin
      t = (tick_count + 1) & 32'h3FF;
      case (phase)
        PH_RESET: begin
          case (slot_idx)
            STG_LOW: begin
              if (t >= reset_low_us) begin
                slot_idx = STG_WAIT;
                t = 0;
              end
            end
            STG_WAIT: begin
              if (t >= presence_wait_us) begin
                no_presence = ln;
                slot_idx = STG_REST;
                t = 0;
              end
            end
            default: begin
              if (t >= reset_rest_us) begin
                done = 1'b1;
                phase = PH_IDLE;
                slot_idx = '0;
                t = 0;
              end
            end
          endcase
          tick_count = t[9:0];
        end
        PH_WRITE: begin
          slot_end = umax(umax(slot_len_us, write_low_len()), 1);
          if (t >= slot_end) shifter = shifter >> 1;
          if (end_of_slot(slot_end, t)) begin
            done = 1'b1;
            phase = PH_IDLE;
          end
        end
        default: begin
          slot_end = umax(umax(slot_len_us, short_low_us), sample_point());
          if (t == sample_point()) shifter = {ln, shifter[7:1]};
          if (end_of_slot(slot_end, t)) begin
            last_read = shifter;
            done = 1'b1;
            phase = PH_IDLE;
          end
        end
      endcase
    end
    r.line_low    = drive_low();
    r.busy        = (phase != PH_IDLE);
    r.done        = done;
    r.no_presence = no_presence;
    r.read_data   = last_read;
    r.rejected    = rej;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned wanted,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= 25)
      $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, wanted, got);
  endtask

  task automatic check_field(input string what, input int unsigned wanted,
                             input int unsigned got);
    if (wanted != got) report_mismatch(what, wanted, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_low_us     = 10'd480;
      presence_wait_us = 8'd70;
      reset_rest_us    = 10'd410;
      short_low_us     = 6'd6;
      zero_low_us      = 7'd60;
      read_sample_us   = 7'd15;
      slot_len_us      = 8'd70;
      phase       = PH_IDLE;
      tick_count  = '0;
      slot_idx    = '0;
      shifter     = '0;
      no_presence = 1'b1;
      last_read   = '0;
      expected_replies.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        reg_now = '0;
        case (cfg_paddr[4:2])
          REG_RESET_LOW:     reg_now = reset_low_us;
          REG_PRESENCE_WAIT: reg_now = presence_wait_us;
          REG_RESET_REST:    reg_now = reset_rest_us;
          REG_SHORT_LOW:     reg_now = short_low_us;
          REG_ZERO_LOW:      reg_now = zero_low_us;
          REG_READ_SAMPLE:   reg_now = read_sample_us;
          REG_SLOT_LEN:      reg_now = slot_len_us;
          default:           reg_now = '0;
        endcase
        if (cfg_pwrite) begin
          case (cfg_paddr[4:2])
            REG_RESET_LOW:     reset_low_us     = cfg_pwdata[9:0];
            REG_PRESENCE_WAIT: presence_wait_us = cfg_pwdata[7:0];
            REG_RESET_REST:    reset_rest_us    = cfg_pwdata[9:0];
            REG_SHORT_LOW:     short_low_us     = cfg_pwdata[5:0];
            REG_ZERO_LOW:      zero_low_us      = cfg_pwdata[6:0];
            REG_READ_SAMPLE:   read_sample_us   = cfg_pwdata[6:0];
            REG_SLOT_LEN:      slot_len_us      = cfg_pwdata[7:0];
            default: ;
          endcase
        end else begin
          check_field("register readback", reg_now, cfg_prdata);
        end
      end

      if (in_tvalid && in_tready)
        expected_replies.push_back(predict_beat(cmd_t'(in_tuser), in_tdata[7:0],
                                                in_tdata[8]));

      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result beat with nothing expected", 0, out_tdata);
        end else begin
          want = expected_replies.pop_front();
          check_field("line_low",         want.line_low,    out_tdata[0]);
          check_field("busy",             want.busy,        out_tdata[1]);
          check_field("done",             want.done,        out_tdata[2]);
          check_field("presence_missing", want.no_presence, out_tdata[3]);
          check_field("read_data",        want.read_data,   out_tdata[11:4]);
          check_field("rejected",         want.rejected,    out_tdata[12]);
          check_field("pad bits",         0,                out_tdata[15:13]);
        end
      end
    end
    due = expected_replies.size();
    busy_flag = (phase != PH_IDLE);
  end

endmodule

FILE: sim/tb_one_wire_master_byte_engine.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the 1-Wire byte engine. The checker beside the DUT
// does all prediction; this module only generates beats, timing settings and
// back-pressure, then reports the outcome.
module tb_one_wire_master_byte_engine;
  import owm_pkg::*;

  typedef enum {STALL_NONE, STALL_SOME, STALL_HEAVY} stall_mode_t;

  logic        clk;
  logic        rst_n;

  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [7:0] write_data, [8] line_in, rest zero
  logic [1:0]  in_tuser;    // [1:0] cmd

  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [0] line_low, [1] busy, [2] done, [3] presence_missing,
                            // [11:4] read_data, [12] rejected, rest zero

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          fail_count;
  int          results_due;
  logic        engine_busy;   // predicted: an operation is in progress

  int          beats_counted = 0;   // beats that are not idle ticks
  int          burst_left = 0;
  logic        hold_off_req = 1'b0;

  one_wire_master_byte_engine u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  owm_bus_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .results_due (results_due),
    .engine_busy (engine_busy)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: the slowest legal run is far below this.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // One input beat. Called at a falling edge, returns at the falling edge after
  // the handshake with tvalid still high, so the next call continues the burst.
  // When a burst runs out, tvalid drops for a random gap.
  task automatic send_beat(input cmd_t c, input logic [7:0] wd, input logic ln);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(9) < 3) ? $urandom_range(60, 250)
                                           : $urandom_range(1, 20);
    end
    if (c != CMD_TICK || engine_busy) beats_counted++;
    in_tuser  = c;
    in_tdata  = {7'd0, ln, wd};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
  endtask

  // A start beat, then ticks until the operation completes. stray_pct of the
  // ticks are replaced by start beats, which the busy engine must reject.
  task automatic run_op(input cmd_t c, input logic [7:0] wd, input int unsigned stray_pct);
    send_beat(c, wd, 1'($urandom));
    while (engine_busy) begin
      if ($urandom_range(99) < stray_pct)
        send_beat(cmd_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
      else
        send_beat(CMD_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  // Finish any running operation, drop tvalid and drain all results.
  task automatic settle();
    while (engine_busy) send_beat(CMD_TICK, 8'($urandom), 1'($urandom));
    in_tvalid = 1'b0;
    wait (results_due == 0);
    repeat (4) @(negedge clk);
  endtask

  // APB setup + access; called at a falling edge.
  task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // New timing set, only with the engine idle and nothing in flight;
  // every register is read back afterwards.
  task automatic program_timing(input int unsigned rl, input int unsigned pw,
                                input int unsigned rr, input int unsigned sl,
                                input int unsigned zl, input int unsigned rs,
                                input int unsigned sn);
    settle();
    apb_xfer(1'b1, REG_RESET_LOW,     32'(rl));
    apb_xfer(1'b1, REG_PRESENCE_WAIT, 32'(pw));
    apb_xfer(1'b1, REG_RESET_REST,    32'(rr));
    apb_xfer(1'b1, REG_SHORT_LOW,     32'(sl));
    apb_xfer(1'b1, REG_ZERO_LOW,      32'(zl));
    apb_xfer(1'b1, REG_READ_SAMPLE,   32'(rs));
    apb_xfer(1'b1, REG_SLOT_LEN,      32'(sn));
    for (int i = REG_RESET_LOW; i <= REG_SLOT_LEN; i++) apb_xfer(1'b0, 3'(i), '0);
  endtask

  // Mostly short timings so ops finish quickly; now and then full range or zero.
  function automatic int unsigned pick(input int unsigned near_hi, input int unsigned top_hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 15) return $urandom_range(top_hi);
    return $urandom_range(near_hi, 1);
  endfunction

  // Mostly complete operations with random data and line levels; some with
  // many stray starts, some loose beats of any kind.
  task automatic random_ops(input int unsigned goal);
    int unsigned stop_at;
    int unsigned r;
    stop_at = beats_counted + goal;
    while (beats_counted < stop_at) begin
      r = $urandom_range(99);
      if (r < 75)
        run_op(cmd_t'($urandom_range(1, 3)), 8'($urandom), 2);
      else if (r < 88)
        run_op(cmd_t'($urandom_range(1, 3)), 8'($urandom), 30);
      else
        repeat ($urandom_range(1, 4))
          send_beat(cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
    end
  endtask

  // Result side: stretches of full speed, light and heavy stalling, plus one
  // long hold-off on request so the output register fills and in_tready drops.
  initial begin : drain_side
    stall_mode_t mode;
    int unsigned stretch;
    logic        held_off;
    held_off   = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_req && !held_off) begin
        held_off   = 1'b1;
        out_tready = 1'b0;
        repeat (300) @(negedge clk);
      end
      mode    = stall_mode_t'($urandom_range(2));
      stretch = $urandom_range(20, 150);
      repeat (stretch) begin
        case (mode)
          STALL_NONE: out_tready = 1'b1;
          STALL_SOME: out_tready = ($urandom_range(3) != 0);
          default:    out_tready = ($urandom_range(9) < 3);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_TICK;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset values: read back, then one byte at default slot timing
    for (int i = REG_RESET_LOW; i <= REG_SLOT_LEN; i++) apb_xfer(1'b0, 3'(i), '0);
    run_op(CMD_WRITE, 8'h96, 0);

    // directed: zero or minimal registers (one-tick reset stages and read slots, sample on first tick)
    program_timing(0, 1, 0, 1, 2, 0, 0);
    send_beat(CMD_TICK, 8'hFF, 1'b1);          // idle tick, nothing moves
    send_beat(CMD_RESET, 8'h00, 1'b0);
    send_beat(CMD_READ, 8'hFF, 1'b1);          // start while busy
    while (engine_busy) send_beat(CMD_TICK, 8'h00, 1'b0);   // device answers
    run_op(CMD_WRITE, 8'hA5, 0);               // mixed long/short slots
    run_op(CMD_READ, 8'h00, 0);

    // lowest legal settings
    program_timing(1, 1, 1, 1, 1, 1, 1);
    random_ops(100);

    // random settings; the long receiver hold-off lands in the first of these
    hold_off_req = 1'b1;
    repeat (4) begin
      program_timing(pick(24, 1023), pick(16, 255), pick(24, 1023), pick(8, 63),
                     pick(16, 127), pick(16, 127), pick(20, 255));
      random_ops(180);
    end

    // highest settings: full-width registers written and read back
    program_timing(1023, 255, 1023, 63, 127, 127, 255);

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
